/* hdl/difficulty_retarget_top_macros.svh */
// assertion macros used by the checker
`ifndef DIFFICULTY_RETARGET_TOP_MACROS_SVH
`define DIFFICULTY_RETARGET_TOP_MACROS_SVH

// same-cycle implication
`define DRT_ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define DRT_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hdl/drt_pkg.sv */
package drt_pkg;

	localparam int WIDE_W     = 256;
	localparam int SPAN_W     = 30;
	localparam int BITS_W     = 32;
	localparam int TIME_W     = 32;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_STAGES = WIDE_W / DIV_STEPS;
	localparam int PIPE_DEPTH = DIV_STAGES + 6;

	localparam logic [SPAN_W-1:0] SPAN0_RST = 30'd1209600;
	localparam logic [SPAN_W-1:0] SPAN1_RST = 30'd300;
	localparam logic [BITS_W-1:0] LIMIT_RST = 32'h1d00ffff;

	typedef enum logic [1:0] {
		REG_DISABLED,
		REG_SPAN0,
		REG_SPAN1,
		REG_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic              disabled;
		logic [SPAN_W-1:0] span0;
		logic [SPAN_W-1:0] span1;
		logic [BITS_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic              dis;
		logic [BITS_W-1:0] bits;
		logic [SPAN_W-1:0] dsr;
		logic [WIDE_W-1:0] x;
	} front_t;

	typedef struct packed {
		logic              dis;
		logic [BITS_W-1:0] bits;
		logic [SPAN_W-1:0] dsr;
		logic [SPAN_W-1:0] rem;
		logic [WIDE_W-1:0] wq;
	} div_stage_t;

	typedef struct packed {
		logic              dis;
		logic [BITS_W-1:0] bits;
		logic [WIDE_W-1:0] q;
	} quot_t;

endpackage

/* hdl/difficulty_retarget_top.sv */
// difficulty retarget, compact target in and out
// input stream: s_tdata carries the previous compact target and the last and
// first block times of the window, s_tuser picks the target timespan
// output stream: m_tdata carries the new compact target, one word per input word
// config: apb registers at 0x0 retarget_disabled, 0x4 timespan_original,
// 0x8 timespan_second, 0xc limit_compact; write only between runs
// latency: 38 cycles from accept to m_tvalid when nothing stalls
// throughput: one word per cycle; clamp and decode, multiply, shift, then
// 32 divider stages retiring 8 quotient bits each, then cap and re-encode
// every stage holds its own valid, so a stalled m_tready fills bubbles first
// and s_tready drops only once all 38 stages hold words
// reset clears all valids and loads the register defaults
// pready is always high, reads return the register value
module difficulty_retarget_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // last_bits, last_block_time, first_block_time
	input  logic [0:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // next_bits
);
	import drt_pkg::*;

	cfg_t    cfg_q;
	logic    f_valid, f_ready, d_valid, d_ready;
	front_t  f_data;
	quot_t   d_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disabled <= 1'b0;
			cfg_q.span0    <= SPAN0_RST;
			cfg_q.span1    <= SPAN1_RST;
			cfg_q.limit    <= LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_DISABLED: cfg_q.disabled <= pwdata[0];
				REG_SPAN0:    cfg_q.span0    <= pwdata[SPAN_W-1:0];
				REG_SPAN1:    cfg_q.span1    <= pwdata[SPAN_W-1:0];
				REG_LIMIT:    cfg_q.limit    <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_DISABLED: prdata = {31'b0, cfg_q.disabled};
			REG_SPAN0:    prdata = {2'b0, cfg_q.span0};
			REG_SPAN1:    prdata = {2'b0, cfg_q.span1};
			REG_LIMIT:    prdata = cfg_q.limit;
		endcase
	end

	drt_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.mode             (s_tuser[0]),
		.last_bits        (s_tdata[31:0]),
		.last_block_time  (s_tdata[63:32]),
		.first_block_time (s_tdata[95:64]),
		.out_valid        (f_valid),
		.out_ready        (f_ready),
		.out_data         (f_data)
	);

	drt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_data  (d_data)
	);

	drt_enc u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_data   (d_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.next_bits (m_tdata)
	);

endmodule

/* hdl/drt_front.sv */
module drt_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  drt_pkg::cfg_t                   cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [drt_pkg::BITS_W-1:0]      last_bits,
	input  logic [drt_pkg::TIME_W-1:0]      last_block_time,
	input  logic [drt_pkg::TIME_W-1:0]      first_block_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output drt_pkg::front_t                 out_data
);
	import drt_pkg::*;

	logic              v_s1, v_s2, v_s3;
	logic              adv1, adv2, adv3;

	logic              dis_s1, dis_s2;
	logic [BITS_W-1:0] bits_s1, bits_s2;
	logic [SPAN_W-1:0] dsr_s1, dsr_s2;
	logic [31:0]       span_s1;
	logic [22:0]       meff_s1;
	logic [4:0]        bsh_s1, bsh_s2;
	logic [54:0]       prod_s2;
	front_t            data_s3;

	logic [SPAN_W-1:0] tgt;
	logic [31:0]       lo, hi, span;
	logic [32:0]       diff;
	logic [7:0]        size;
	logic [22:0]       mant, meff;
	logic [4:0]        bsh;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// timespan clamp, signed difference of unsigned timestamps
	always_comb begin
		tgt  = mode ? cfg.span1 : cfg.span0;
		lo   = {4'b0, tgt[SPAN_W-1:2]};
		hi   = {tgt, 2'b00};
		diff = {1'b0, last_block_time} - {1'b0, first_block_time};
		if (diff[32] || (diff[31:0] < lo)) begin
			span = lo;
		end else if (diff[31:0] > hi) begin
			span = hi;
		end else begin
			span = diff[31:0];
		end
	end

	// compact decode split into a small mantissa and a byte shift
	always_comb begin
		size = last_bits[31:24];
		mant = last_bits[22:0];
		meff = mant;
		bsh  = '0;
		if (size <= 8'd3) begin
			unique case (size[1:0])
				2'd0: meff = '0;
				2'd1: meff = mant >> 16;
				2'd2: meff = mant >> 8;
				2'd3: meff = mant;
			endcase
		end else if (size >= 8'd35) begin
			meff = '0;
		end else begin
			bsh = 5'(size - 8'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			dis_s1  <= cfg.disabled;
			bits_s1 <= last_bits;
			dsr_s1  <= tgt;
			span_s1 <= span;
			meff_s1 <= meff;
			bsh_s1  <= bsh;
		end
		if (adv2) begin
			dis_s2  <= dis_s1;
			bits_s2 <= bits_s1;
			dsr_s2  <= dsr_s1;
			bsh_s2  <= bsh_s1;
			prod_s2 <= 55'(meff_s1) * 55'(span_s1);
		end
		if (adv3) begin
			data_s3.dis  <= dis_s2;
			data_s3.bits <= bits_s2;
			data_s3.dsr  <= dsr_s2;
			// bits shifted past the top are dropped
			data_s3.x    <= WIDE_W'(prod_s2) << {bsh_s2, 3'b000};
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

/* hdl/drt_div.sv */
module drt_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  drt_pkg::front_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output drt_pkg::quot_t   out_data
);
	import drt_pkg::*;

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES:0]   vin;
	logic [DIV_STAGES:0]   adv;
	div_stage_t            st_s [DIV_STAGES];
	div_stage_t            nxt  [DIV_STAGES];

	assign vin = {vld_s, in_valid};

	// stall ripples back from the output combinationally through every full stage
	always_comb begin
		adv[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end
	assign in_ready = adv[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		div_stage_t        cur;
		logic [SPAN_W:0]   t;

		if (k == 0) begin : g_first
			assign cur = '{dis: in_data.dis, bits: in_data.bits, dsr: in_data.dsr,
				rem: '0, wq: in_data.x};
		end else begin : g_rest
			assign cur = st_s[k-1];
		end

		// restoring steps: dividend shifts out the top, quotient in at the bottom
		always_comb begin
			nxt[k] = cur;
			t      = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				t = {nxt[k].rem, nxt[k].wq[WIDE_W-1]};
				nxt[k].wq = {nxt[k].wq[WIDE_W-2:0], 1'b0};
				if (t >= {1'b0, nxt[k].dsr}) begin
					nxt[k].rem   = SPAN_W'(t - {1'b0, nxt[k].dsr});
					nxt[k].wq[0] = 1'b1;
				end else begin
					nxt[k].rem = t[SPAN_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (adv[k]) vld_s[k] <= vin[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (adv[k]) st_s[k] <= nxt[k];
		end
	end

	assign out_valid     = vld_s[DIV_STAGES-1];
	assign out_data.dis  = st_s[DIV_STAGES-1].dis;
	assign out_data.bits = st_s[DIV_STAGES-1].bits;
	assign out_data.q    = st_s[DIV_STAGES-1].wq;

endmodule

/* hdl/drt_enc.sv */
module drt_enc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  drt_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  drt_pkg::quot_t              in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [drt_pkg::BITS_W-1:0]  next_bits
);
	import drt_pkg::*;

	logic              v_s1, v_s2, v_s3;
	logic              adv1, adv2, adv3;
	logic              dis_s1, dis_s2;
	logic [BITS_W-1:0] bits_s1, bits_s2;
	logic [WIDE_W-1:0] q_s1, q_s2;
	logic [5:0]        nb_s2;
	logic [BITS_W-1:0] res_s3;

	logic [WIDE_W-1:0] lim;
	logic [7:0]        lsize;
	logic [5:0]        nb;
	logic [23:0]       mant;
	logic [5:0]        esize;
	logic [7:0]        base;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// limit decoded to full width
	always_comb begin
		lsize = cfg.limit[31:24];
		lim   = '0;
		if (lsize <= 8'd3) begin
			unique case (lsize[1:0])
				2'd0: lim = '0;
				2'd1: lim = WIDE_W'(cfg.limit[22:16]);
				2'd2: lim = WIDE_W'(cfg.limit[22:8]);
				2'd3: lim = WIDE_W'(cfg.limit[22:0]);
			endcase
		end else if (lsize < 8'd35) begin
			lim = WIDE_W'(cfg.limit[22:0]) << {5'(lsize - 8'd3), 3'b000};
		end
	end

	// byte count up to the highest nonzero byte
	always_comb begin
		nb = '0;
		for (int i = 0; i < WIDE_W / 8; i++) begin
			if (|q_s1[8*i +: 8]) nb = 6'(i + 1);
		end
	end

	always_comb begin
		base = {5'(nb_s2 - 6'd3), 3'b000};
		mant = '0;
		if (nb_s2 <= 6'd3) begin
			unique case (nb_s2[1:0])
				2'd0: mant = '0;
				2'd1: mant = {q_s2[7:0], 16'h0000};
				2'd2: mant = {q_s2[15:0], 8'h00};
				2'd3: mant = q_s2[23:0];
			endcase
		end else begin
			mant = q_s2[base +: 24];
		end
		esize = nb_s2;
		// keep the sign bit clear
		if (mant[23]) begin
			mant  = mant >> 8;
			esize = nb_s2 + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			dis_s1  <= in_data.dis;
			bits_s1 <= in_data.bits;
			q_s1    <= (in_data.q > lim) ? lim : in_data.q;
		end
		if (adv2) begin
			dis_s2  <= dis_s1;
			bits_s2 <= bits_s1;
			q_s2    <= q_s1;
			nb_s2   <= nb;
		end
		if (adv3) begin
			res_s3 <= dis_s2 ? bits_s2 : {2'b00, esize, mant};
		end
	end

	assign out_valid = v_s3;
	assign next_bits = res_s3;

endmodule

/* hdl/drt_checker.sv */
`include "difficulty_retarget_top_macros.svh"

module drt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import drt_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             s_acc, m_acc, wr_lim, lim_sel;

	assign s_acc   = s_tvalid && s_tready;
	assign m_acc   = m_tvalid && m_tready;
	assign lim_sel = (reg_idx_t'(paddr[3:2]) == REG_LIMIT);
	assign wr_lim  = psel && penable && pwrite && pready && lim_sel;

	// words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (s_acc && !m_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (m_acc && !s_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	`DRT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`DRT_ASSERT_SAME(a_no_phantom, clk, arst_n, m_tvalid, inflight_q != '0)
	`DRT_ASSERT_SAME(a_full_stalls, clk, arst_n, (inflight_q == CNT_W'(PIPE_DEPTH)) && !m_tready, !s_tready)
	`DRT_ASSERT_NEXT(a_limit_readback, clk, arst_n, wr_lim, pwrite || !lim_sel || (prdata == $past(pwdata)))

endmodule

bind difficulty_retarget_top drt_checker u_drt_checker (.*);

/* verif/tb_difficulty_retarget_top.sv */
module tb_difficulty_retarget_top;
	timeunit 1ns;
	timeprecision 1ps;
	import drt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // last_bits, last_block_time, first_block_time
	logic [0:0]  s_tuser;   // mode
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // next_bits

	difficulty_retarget_top u_dut (.*);

	// shadow of the block's registers
	logic              cfg_disabled;
	logic [SPAN_W-1:0] cfg_span0;
	logic [SPAN_W-1:0] cfg_span1;
	logic [BITS_W-1:0] cfg_limit;

	logic [31:0] expected_bits[$];
	int          mismatches;
	int          words_sent;
	int          words_checked;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [255:0] decode_target(logic [31:0] c);
		logic [255:0] v;
		int           size;
		size = int'(c[31:24]);
		v = 256'(c[22:0]);
		if (size <= 3)
			v = v >> (8 * (3 - size));
		else if (size - 3 < 32)
			v = v << (8 * (size - 3));
		else
			v = '0;
		return v;
	endfunction

	function automatic logic [31:0] encode_target(logic [255:0] v);
		int          nbits;
		int          size;
		logic [31:0] mant;
		nbits = 0;
		for (int i = 0; i < 256; i++)
			if (v[i])
				nbits = i + 1;
		size = (nbits + 7) / 8;
		if (size <= 3)
			mant = v[31:0] << (8 * (3 - size));
		else
			mant = 32'(v >> (8 * (size - 3))) & 32'h00ff_ffff;
		if (mant[23]) begin
			mant = mant >> 8;
			size++;
		end
		return (mant & 32'h00ff_ffff) | (32'(size) << 24);
	endfunction

	function automatic logic [31:0] retarget(logic mode, logic [31:0] bits,
			logic [31:0] t_last, logic [31:0] t_first);
		longint       span;
		longint       tgt;
		logic [255:0] prod;
		logic [255:0] quo;
		logic [255:0] lim;
		if (cfg_disabled)
			return bits;
		tgt = mode ? longint'(cfg_span1) : longint'(cfg_span0);
		span = longint'(t_last) - longint'(t_first);
		if (span < tgt / 4)
			span = tgt / 4;
		if (span > tgt * 4)
			span = tgt * 4;
		prod = decode_target(bits) * 256'(span[31:0]);
		quo = (tgt == 0) ? {256{1'b1}} : prod / 256'(tgt);
		lim = decode_target(cfg_limit);
		if (quo > lim)
			quo = lim;
		return encode_target(quo);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		s_tvalid <= 1'b0;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx) << 2;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DISABLED: cfg_disabled = val[0];
			REG_SPAN0:    cfg_span0 = val[SPAN_W-1:0];
			REG_SPAN1:    cfg_span1 = val[SPAN_W-1:0];
			REG_LIMIT:    cfg_limit = val;
		endcase
	endtask

	// tvalid stays high after a word, so words sent with no random gap go back to back
	task automatic send_word(logic mode, logic [31:0] bits, logic [31:0] t_last,
			logic [31:0] t_first, bit with_gaps = 1);
		int gap;
		gap = with_gaps ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		expected_bits.push_back(retarget(mode, bits, t_last, t_first));
		s_tvalid <= 1'b1;
		s_tdata  <= {t_first, t_last, bits};
		s_tuser  <= mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_bits.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	// random compact target, mostly near realistic exponents
	function automatic logic [31:0] rand_bits();
		logic [31:0] b;
		b = $urandom();
		if ($urandom_range(0, 3) != 0)
			b[31:24] = $urandom_range(0, 36);
		return b;
	endfunction

	task automatic send_random(int n, bit with_gaps = 1);
		logic [31:0] t_first;
		logic [31:0] t_last;
		logic        mode;
		longint      tgt;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 1);
			tgt = mode ? cfg_span1 : cfg_span0;
			t_first = $urandom();
			case ($urandom_range(0, 3))
				0: t_last = $urandom();
				1: t_last = t_first + 32'($urandom_range(0, 32'(tgt * 5 + 8)));
				2: t_last = t_first - 32'($urandom_range(0, 1000));
				default: t_last = t_first + 32'(tgt);
			endcase
			send_word(mode, rand_bits(), t_last, t_first, with_gaps);
		end
	endtask

	task automatic test_directed();
		send_word(1'b0, 32'h1d00_ffff, 32'd1209600, 32'd0);
		send_word(1'b0, 32'h1d00_ffff, 32'd100, 32'd0);
		send_word(1'b0, 32'h1b04_04cb, 32'd100, 32'd0);
		send_word(1'b0, 32'h1b04_04cb, 32'hffff_ffff, 32'd0);
		send_word(1'b1, 32'h1b04_04cb, 32'd0, 32'hffff_ffff);
		send_word(1'b1, 32'h0000_0000, 32'd300, 32'd0);
		send_word(1'b1, 32'hffff_ffff, 32'd300, 32'd0);
		send_word(1'b1, 32'h0380_0000, 32'd600, 32'd0);
		send_word(1'b0, 32'h0112_3456, 32'd1209600, 32'd0);
		send_word(1'b0, 32'h0212_3456, 32'd1209600, 32'd0);
		send_word(1'b1, 32'h2000_0001, 32'd1200, 32'd0);
		send_word(1'b1, 32'h217f_ffff, 32'd1200, 32'd0);
		send_word(1'b1, 32'h0400_8000, 32'd300, 32'd300);
	endtask

	task automatic test_disabled();
		write_reg(REG_DISABLED, 32'd1);
		send_word(1'b0, 32'hffff_ffff, 32'd5, 32'd9);
		send_word(1'b1, 32'h0000_0000, 32'd0, 32'd0);
		send_random(20);
		drain();
		write_reg(REG_DISABLED, 32'd0);
	endtask

	task automatic test_span_extremes();
		write_reg(REG_SPAN0, 32'd0);
		write_reg(REG_SPAN1, 32'd3);
		write_reg(REG_LIMIT, 32'hffff_ffff);
		send_word(1'b0, 32'h1d00_ffff, 32'd77, 32'd0);
		send_word(1'b1, 32'h1d00_ffff, 32'd77, 32'd0);
		send_word(1'b1, 32'h1d00_ffff, 32'd0, 32'd1);
		send_random(40);
		drain();
		write_reg(REG_SPAN0, 32'h3fff_ffff);
		write_reg(REG_SPAN1, 32'd4);
		write_reg(REG_LIMIT, 32'h0000_0000);
		send_random(40);
		drain();
		write_reg(REG_LIMIT, 32'h1d80_ffff);
		send_random(40);
		drain();
	endtask

	task automatic test_random_configs();
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_SPAN0, $urandom_range(4, 2000000));
			write_reg(REG_SPAN1, $urandom_range(4, 5000));
			write_reg(REG_LIMIT, ($urandom_range(0, 1) != 0) ? $urandom() :
				{8'($urandom_range(3, 34)), 24'($urandom())});
			send_random(100, phase != 2);
			drain();
		end
		write_reg(REG_SPAN0, 32'(SPAN0_RST));
		write_reg(REG_SPAN1, 32'(SPAN1_RST));
		write_reg(REG_LIMIT, LIMIT_RST);
		send_random(60);
	endtask

	// result checker with random backpressure
	initial begin
		int          stall;
		logic [31:0] want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			words_checked++;
			if (expected_bits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", m_tdata);
			end else begin
				want = expected_bits.pop_front();
				if (m_tdata !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("next_bits mismatch: expected %h actual %h", want, m_tdata);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		cfg_disabled = 1'b0;
		cfg_span0 = SPAN0_RST;
		cfg_span1 = SPAN1_RST;
		cfg_limit = LIMIT_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		drain();
		test_disabled();
		test_span_extremes();
		test_random_configs();
		drain();
		if (expected_bits.size() != 0)
			mismatches++;
		$display("sent %0d words and checked %0d results", words_sent, words_checked);
		$display("covered bypass, zero and tiny timespans, extreme limits and random settings");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
